// ===== rtl/assert_macros.svh =====
// Assertion macros used by the pacer core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ddp_pkg.sv =====
// Shared types and constants for the datagram deadline pacer.
package ddp_pkg;

  localparam logic [29:0] NsPerS = 30'd1000000000;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StOverCap  = 3'd2;
  localparam logic [2:0] StDeadline = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;

  localparam logic [1:0] RegBase = 2'd0;
  localparam logic [1:0] RegMax  = 2'd1;
  localparam logic [1:0] RegLim  = 2'd2;
  localparam logic [1:0] RegGen  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL1, S_DIV1, S_RATE, S_MUL2, S_DIV2,
    S_WIN, S_GRANT, S_SUBMIT, S_OUT
  } state_e;

  // Divider handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic        rem_nz;
  } div_rsp_t;

  // Serial multiplier handshake.
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [29:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

endpackage

// ===== rtl/datagram_deadline_pacer_core.sv =====
// Datagram pacer: reserve/submit sequencer with serial multiplier and divider.
// A reserve steps through check, multiply, divide, rate test, multiply,
// divide, window and grant; an over-capacity reserve ends at the rate test,
// an invalid one at the check; a submit has one check step. One item at a
// time; the next beat can be taken in the cycle after the result beat leaves.
// Reset is asynchronous and active low; state and counters return to defaults, captured data does not.
module datagram_deadline_pacer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] generation_i,
  input  logic [31:0] endpoint_id_i,
  input  logic [62:0] pacing_sequence_i,
  input  logic [15:0] wire_bytes_i,
  input  logic [31:0] queue_wire_bytes_i,
  input  logic signed [62:0] queue_residence_ns_i,
  input  logic signed [62:0] release_ns_i,
  input  logic signed [62:0] deadline_ns_i,
  input  logic signed [62:0] now_ns_i,
  input  logic signed [62:0] submit_start_ns_i,
  input  logic signed [62:0] submit_done_ns_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic signed [62:0] win_open_ns_o,
  output logic signed [62:0] win_close_ns_o,
  output logic [61:0] serve_ns_o,
  output logic [31:0] granted_rate_o,
  output logic [63:0] reserved_count_o,
  output logic [63:0] submitted_count_o,
  output logic [63:0] adaptation_count_o,
  output logic [31:0] peak_rate_o,
  output logic [61:0] max_lateness_ns_o,
  output logic [62:0] worst_late_sequence_o,
  output logic        saturated_o
);
  import ddp_pkg::*;
  `include "assert_macros.svh"

  localparam logic signed [63:0] TimeMax = 64'sh3FFFFFFFFFFFFFFF;

  // Configuration
  logic [31:0] base_q, maxr_q, gen_q;
  logic [61:0] lim_q;
  logic [1:0]  ridx;
  logic        cfg_we;

  assign pready = 1'b1;
  assign ridx   = paddr[4:3];
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd125000;
      maxr_q <= 32'd1250000;
      lim_q  <= 62'd100000000;
      gen_q  <= 32'd1;
    end else if (cfg_we && paddr[2:0] == 3'd0) begin
      case (ridx)
        RegBase: base_q <= pwdata[31:0];
        RegMax:  maxr_q <= pwdata[31:0];
        RegLim:  lim_q  <= pwdata[61:0];
        RegGen:  gen_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegBase: prdata = {32'd0, base_q};
      RegMax:  prdata = {32'd0, maxr_q};
      RegLim:  prdata = {2'd0, lim_q};
      RegGen:  prdata = {32'd0, gen_q};
      default: prdata = '0;
    endcase
  end

  // Serial units
  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  ddp_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
  ddp_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Captured item
  logic        op_q;
  logic [31:0] igen_q, ep_q, qb_q;
  logic [62:0] seq_q;
  logic [15:0] wb_q;
  logic signed [63:0] res_q, rel_q, dl_q, now_q, st_q, dn_q;

  // Architectural state
  logic        pend_v_q, tat_v_q, lt_v_q, ls_v_q, sat_q;
  logic [62:0] pend_seq_q, last_seq_q, late_seq_q;
  logic signed [63:0] pend_st_q, pend_end_q, tat_q, lt_q;
  logic [62:0] pend_dur_q, late_max_q;
  logic [63:0] rsv_q, sub_q, adp_q;
  logic [31:0] peak_q;

  // Working registers
  state_e      state_q, state_d;
  logic [63:0] work_q;
  logic [63:0] rate_q;
  logic [2:0]  st_res_q;
  logic signed [63:0] nb_q, na_q;

  logic [63:0] divq;
  logic        in_acc, out_acc;
  logic        rsv_bad, sub_bad;
  logic signed [63:0] nb_c, eff_c, na_c;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign divq    = drsp.quo + {63'd0, drsp.rem_nz};

  assign rsv_bad = pend_v_q || igen_q != gen_q || ep_q == '0 || seq_q == '0 ||
                   wb_q == '0 || qb_q < {16'd0, wb_q} || res_q < 0 ||
                   res_q >= $signed({2'b00, lim_q}) || rel_q < 0 ||
                   dl_q <= rel_q || now_q < 0 || (lt_v_q && now_q < lt_q) ||
                   (ls_v_q && seq_q <= last_seq_q);

  assign sub_bad = !pend_v_q || seq_q != pend_seq_q || st_q < pend_st_q ||
                   st_q >= pend_end_q || dn_q < st_q || dn_q >= pend_end_q ||
                   (lt_v_q && st_q < lt_q);

  assign nb_c  = (tat_v_q && tat_q > rel_q) ? tat_q : rel_q;
  assign na_c  = dl_q - $signed(work_q);
  assign eff_c = (now_q > nb_q) ? now_q : nb_q;

  always_comb begin
    state_d     = state_q;
    mreq        = '0;
    dreq        = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = operation_i ? S_SUBMIT : S_CHECK;
      end
      S_CHECK: begin
        mreq.start = !rsv_bad;
        mreq.a     = qb_q;
        mreq.b     = NsPerS;
        state_d    = rsv_bad ? S_OUT : S_MUL1;
      end
      S_MUL1: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = mrsp.prod;
          dreq.den   = {2'd0, lim_q} - res_q;
          state_d    = S_DIV1;
        end
      end
      S_DIV1: if (drsp.done) state_d = S_RATE;
      S_RATE: begin
        if (rate_q > {32'd0, maxr_q}) begin
          state_d = S_OUT;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = {16'd0, wb_q};
          mreq.b     = NsPerS;
          state_d    = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = mrsp.prod;
          dreq.den   = rate_q;
          state_d    = S_DIV2;
        end
      end
      S_DIV2: if (drsp.done) state_d = S_WIN;
      S_WIN:  state_d = S_GRANT;
      S_GRANT: state_d = S_OUT;
      S_SUBMIT: state_d = S_OUT;
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_v_q   <= 1'b0;
      tat_v_q    <= 1'b0;
      lt_v_q     <= 1'b0;
      ls_v_q     <= 1'b0;
      sat_q      <= 1'b0;
      pend_seq_q <= '0;
      pend_st_q  <= '0;
      pend_end_q <= '0;
      pend_dur_q <= '0;
      tat_q      <= '0;
      lt_q       <= '0;
      last_seq_q <= '0;
      rsv_q      <= '0;
      sub_q      <= '0;
      adp_q      <= '0;
      peak_q     <= 32'd125000;
      late_max_q <= '0;
      late_seq_q <= '0;
      st_res_q   <= StOk;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: st_res_q <= StOk;
        S_CHECK: if (rsv_bad) st_res_q <= StInvalid;
        S_RATE: if (rate_q > {32'd0, maxr_q}) st_res_q <= StOverCap;
        S_GRANT: begin
          if (eff_c >= na_q) begin
            st_res_q <= StDeadline;
          end else if (rsv_q == '1 || (rate_q > {32'd0, base_q} && adp_q == '1)) begin
            st_res_q <= StOverflow;
            sat_q    <= 1'b1;
          end else begin
            pend_v_q   <= 1'b1;
            pend_seq_q <= seq_q;
            pend_st_q  <= nb_q;
            pend_end_q <= na_q;
            pend_dur_q <= work_q[62:0];
            lt_v_q     <= 1'b1;
            lt_q       <= now_q;
            if (rate_q > {32'd0, base_q}) adp_q <= adp_q + 64'd1;
            if (rate_q > {32'd0, peak_q}) peak_q <= rate_q[31:0];
            rsv_q <= rsv_q + 64'd1;
          end
        end
        S_SUBMIT: begin
          if (sub_bad) begin
            st_res_q <= StInvalid;
          end else if (dn_q > TimeMax - $signed({1'b0, pend_dur_q}) || sub_q == '1) begin
            st_res_q <= StOverflow;
            sat_q    <= 1'b1;
          end else begin
            if ((st_q - pend_st_q) > $signed({1'b0, late_max_q})) begin
              late_max_q <= 63'(st_q - pend_st_q);
              late_seq_q <= seq_q;
            end
            tat_v_q    <= 1'b1;
            tat_q      <= dn_q + $signed({1'b0, pend_dur_q});
            lt_v_q     <= 1'b1;
            lt_q       <= dn_q;
            ls_v_q     <= 1'b1;
            last_seq_q <= seq_q;
            pend_v_q   <= 1'b0;
            sub_q      <= sub_q + 64'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      igen_q <= generation_i;
      ep_q   <= endpoint_id_i;
      seq_q  <= pacing_sequence_i;
      wb_q   <= wire_bytes_i;
      qb_q   <= queue_wire_bytes_i;
      res_q  <= 64'(queue_residence_ns_i);
      rel_q  <= 64'(release_ns_i);
      dl_q   <= 64'(deadline_ns_i);
      now_q  <= 64'(now_ns_i);
      st_q   <= 64'(submit_start_ns_i);
      dn_q   <= 64'(submit_done_ns_i);
    end
    if (state_q == S_DIV1 && drsp.done) begin
      rate_q <= (divq > {32'd0, base_q}) ? divq : {32'd0, base_q};
    end
    if (state_q == S_DIV2 && drsp.done) work_q <= divq;
    if (state_q == S_WIN) begin
      nb_q <= nb_c;
      na_q <= na_c;
    end
  end

  // Peak starts at the reset value of base_rate; tracked through the reset default above.
  logic grant_ok;
  assign grant_ok = st_res_q == StOk && !op_q;

  assign status_o            = st_res_q;
  assign win_open_ns_o       = grant_ok ? nb_q[62:0] : '0;
  assign win_close_ns_o      = grant_ok ? na_q[62:0] : '0;
  assign serve_ns_o          = grant_ok ? work_q[61:0] : '0;
  assign granted_rate_o      = grant_ok ? rate_q[31:0] : '0;
  assign reserved_count_o    = rsv_q;
  assign submitted_count_o   = sub_q;
  assign adaptation_count_o  = adp_q;
  assign peak_rate_o         = peak_q;
  assign max_lateness_ns_o   = late_max_q[61:0];
  assign worst_late_sequence_o = late_seq_q;
  assign saturated_o         = sat_q;

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE)
  `ASSERT_IMPL(a_no_both, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

// ===== rtl/ddp_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
module ddp_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddp_pkg::mul_req_t req_i,
  output ddp_pkg::mul_rsp_t rsp_o
);
  import ddp_pkg::*;

  logic [63:0] acc_q, acc_d, mc_q, mc_d;
  logic [29:0] mp_q, mp_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = '0;
      mc_d   = {32'd0, req_i.a};
      mp_d   = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) acc_d = acc_q + mc_q;
      mc_d  = {mc_q[62:0], 1'b0};
      mp_d  = {1'b0, mp_q[29:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd29) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== rtl/ddp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ddp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddp_pkg::div_req_t req_i,
  output ddp_pkg::div_rsp_t rsp_o
);
  import ddp_pkg::*;

  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d, den_q, den_d;
  logic [64:0] trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  assign trial = {rem_q[63:0], quo_q[63]} - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[63:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quo    = quo_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// ===== verif/datagram_deadline_pacer_core_test.sv =====
// Self-checking testbench for the datagram deadline pacer core.
`timescale 1ns / 100ps

module datagram_deadline_pacer_core_test;
  import ddp_pkg::*;

  localparam logic OpReserve = 1'b0;
  localparam logic OpSubmit  = 1'b1;
  localparam longint TimeMax = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned NsPerSec = 64'd1000000000;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic               op;
    logic [31:0]        gen;
    logic [31:0]        ep;
    logic [62:0]        seq;
    logic [15:0]        wb;
    logic [31:0]        qb;
    logic signed [62:0] res;
    logic signed [62:0] rel;
    logic signed [62:0] dl;
    logic signed [62:0] now;
    logic signed [62:0] st;
    logic signed [62:0] dn;
  } pace_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [62:0] nb;
    logic [62:0] na;
    logic [61:0] dur;
    logic [31:0] rate;
    logic [63:0] n_resv;
    logic [63:0] n_subm;
    logic [63:0] n_adapt;
    logic [31:0] peak;
    logic [61:0] late;
    logic [62:0] late_seq;
    logic        sat;
  } pace_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pace_req_t drv = '{default: '0};
  logic [2:0]  status_o;
  logic [62:0] win_open_ns_o, win_close_ns_o;
  logic [61:0] serve_ns_o;
  logic [31:0] granted_rate_o;
  logic [63:0] reserved_count_o, submitted_count_o, adaptation_count_o;
  logic [31:0] peak_rate_o;
  logic [61:0] max_lateness_ns_o;
  logic [62:0] worst_late_sequence_o;
  logic saturated_o;

  datagram_deadline_pacer_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .operation_i(drv.op), .generation_i(drv.gen), .endpoint_id_i(drv.ep),
    .pacing_sequence_i(drv.seq), .wire_bytes_i(drv.wb), .queue_wire_bytes_i(drv.qb),
    .queue_residence_ns_i(drv.res), .release_ns_i(drv.rel), .deadline_ns_i(drv.dl),
    .now_ns_i(drv.now), .submit_start_ns_i(drv.st), .submit_done_ns_i(drv.dn),
    .out_valid_o, .out_ready_i, .status_o, .win_open_ns_o, .win_close_ns_o,
    .serve_ns_o, .granted_rate_o, .reserved_count_o, .submitted_count_o,
    .adaptation_count_o, .peak_rate_o, .max_lateness_ns_o, .worst_late_sequence_o,
    .saturated_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // pacer shadow: configuration and state
  longint unsigned cfg_base = 125000, cfg_max = 1250000, cfg_lim = 100000000;
  longint unsigned cfg_gen = 1;
  bit pend_ok, tat_ok, seen_ok, seq_ok, sat;
  longint unsigned pend_seq, pend_dur, seq_last;
  longint pend_start, pend_end, tat, seen_ns;
  longint unsigned n_resv, n_subm, n_adapt, peak = 125000, late_max, late_seq;

  pace_rsp_t grant_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int sink_stall = 0;

  function automatic longint unsigned rnd64(longint unsigned n);
    if (n == 0) return 0;
    return {$urandom, $urandom} % n;
  endfunction

  function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
    return n / d + ((n % d) != 0);
  endfunction

  function automatic longint unsigned pacing_rate(longint unsigned qb, longint res);
    longint unsigned need;
    need = cdiv(qb * NsPerSec, cfg_lim - longint'(res));
    return (need > cfg_base) ? need : cfg_base;
  endfunction

  function automatic pace_rsp_t pace_step(pace_req_t it);
    pace_rsp_t r;
    longint res, rel, dl, now, st, dn, nb, na, eff;
    longint unsigned rate, dur, late;
    bit adapt;
    r = '{default: '0};
    res = it.res; rel = it.rel; dl = it.dl; now = it.now; st = it.st; dn = it.dn;
    if (it.op == OpReserve) begin
      if (pend_ok || it.gen != cfg_gen[31:0] || it.ep == 0 || it.seq == 0 ||
          it.wb == 0 || it.qb < it.wb || res < 0 || longint'(cfg_lim) <= res ||
          rel < 0 || dl <= rel || now < 0 || (seen_ok && now < seen_ns) ||
          (seq_ok && it.seq <= seq_last)) begin
        r.status = StInvalid;
      end else begin
        rate = pacing_rate(it.qb, res);
        if (rate > cfg_max) begin
          r.status = StOverCap;
        end else begin
          dur = cdiv(longint'(it.wb) * NsPerSec, rate);
          nb = (tat_ok && tat > rel) ? tat : rel;
          na = dl - longint'(dur);
          eff = (now > nb) ? now : nb;
          adapt = rate > cfg_base;
          if (eff >= na) begin
            r.status = StDeadline;
          end else if (n_resv == '1 || (adapt && n_adapt == '1)) begin
            sat = 1'b1;
            r.status = StOverflow;
          end else begin
            pend_ok = 1'b1; pend_seq = it.seq; pend_start = nb; pend_end = na;
            pend_dur = dur; seen_ok = 1'b1; seen_ns = now;
            if (adapt) n_adapt++;
            if (rate > peak) peak = rate;
            n_resv++;
            r.status = StOk;
            r.nb = nb[62:0]; r.na = na[62:0]; r.dur = dur[61:0]; r.rate = rate[31:0];
          end
        end
      end
    end else begin
      if (!pend_ok || it.seq != pend_seq || st < pend_start || st >= pend_end ||
          dn < st || dn >= pend_end || (seen_ok && st < seen_ns)) begin
        r.status = StInvalid;
      end else if (dn > TimeMax - longint'(pend_dur) || n_subm == '1) begin
        sat = 1'b1;
        r.status = StOverflow;
      end else begin
        late = st - pend_start;
        if (late > late_max) begin
          late_max = late;
          late_seq = it.seq;
        end
        tat_ok = 1'b1; tat = dn + longint'(pend_dur);
        seen_ok = 1'b1; seen_ns = dn;
        seq_ok = 1'b1; seq_last = it.seq;
        pend_ok = 1'b0;
        n_subm++;
        r.status = StOk;
      end
    end
    r.n_resv = n_resv; r.n_subm = n_subm; r.n_adapt = n_adapt; r.peak = peak[31:0];
    r.late = late_max[61:0]; r.late_seq = late_seq[62:0]; r.sat = sat;
    return r;
  endfunction

  // reserve that fits the current state, deadline usually reachable
  function automatic pace_req_t fresh_reserve();
    pace_req_t it;
    longint now, rel, lo;
    longint unsigned dur;
    it = '{default: '0};
    it.op = OpReserve;
    it.gen = cfg_gen[31:0];
    it.ep = $urandom | 32'd1;
    it.seq = 63'((seq_ok ? seq_last : 0) + 1 + $urandom_range(0, 3));
    it.wb = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) :
                                          16'($urandom_range(1, 1500));
    it.qb = 32'(it.wb + $urandom_range(0, 150000));
    it.res = $urandom_range(0, 1) ? 63'd0 : 63'(rnd64(cfg_lim));
    now = (seen_ok ? seen_ns : 0) + $urandom_range(0, 2000000);
    rel = $urandom_range(0, 1) ? now - $urandom_range(0, 1000000) : now + $urandom_range(0, 1000000);
    if (rel < 0) rel = 0;
    dur = cdiv(longint'(it.wb) * NsPerSec, pacing_rate(it.qb, it.res));
    lo = (tat_ok && tat > rel) ? tat : rel;
    if (now > lo) lo = now;
    it.now = 63'(now);
    it.rel = 63'(rel);
    it.dl = 63'(lo + longint'(dur) + $urandom_range(1, 3000000) -
            (($urandom_range(0, 7) == 0) ? $urandom_range(0, 6000000) : 0));
    return it;
  endfunction

  function automatic pace_req_t fresh_submit();
    pace_req_t it;
    longint lo, st;
    it = '{default: '0};
    it.op = OpSubmit;
    it.seq = pend_ok ? 63'(pend_seq) : 63'($urandom_range(1, 100));
    lo = (seen_ok && seen_ns > pend_start) ? seen_ns : pend_start;
    st = (pend_end > lo) ? lo + longint'(rnd64(pend_end - lo)) : lo;
    it.st = 63'(st);
    it.dn = 63'((pend_end > st) ? st + longint'(rnd64(pend_end - st)) : st);
    return it;
  endfunction

  function automatic pace_req_t noise_item();
    pace_req_t it;
    it.op = 1'($urandom); it.gen = $urandom; it.ep = $urandom;
    it.seq = 63'({$urandom, $urandom}); it.wb = 16'($urandom); it.qb = $urandom;
    it.res = 63'({$urandom, $urandom}); it.rel = 63'({$urandom, $urandom});
    it.dl = 63'({$urandom, $urandom}); it.now = 63'({$urandom, $urandom});
    it.st = 63'({$urandom, $urandom}); it.dn = 63'({$urandom, $urandom});
    return it;
  endfunction

  task automatic send_beat(pace_req_t it);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    drv = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    grant_q.push_back(pace_step(it));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (grant_q.size() == 0);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, longint unsigned val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      RegBase: cfg_base = val[31:0];
      RegMax:  cfg_max = val[31:0];
      RegLim:  cfg_lim = val[61:0];
      default: cfg_gen = val[31:0];
    endcase
  endtask

  task automatic program_rates(longint unsigned b, longint unsigned m,
                               longint unsigned l, longint unsigned g);
    drain();
    apb_write(RegBase, b);
    apb_write(RegMax, m);
    apb_write(RegLim, l);
    apb_write(RegGen, g);
  endtask

  task automatic test_directed();
    pace_req_t it, ok;
    ok = fresh_reserve();
    ok.qb = {16'd0, ok.wb};
    ok.res = '0;
    it = ok; it.gen = cfg_gen[31:0] + 32'd1;   send_beat(it);
    it = ok; it.ep = '0;                       send_beat(it);
    it = ok; it.seq = '0;                      send_beat(it);
    it = ok; it.wb = '0;                       send_beat(it);
    it = ok; it.qb = {16'd0, ok.wb - 16'd1};   send_beat(it);
    it = ok; it.res = '1;                      send_beat(it);
    it = ok; it.res = 63'(cfg_lim);            send_beat(it);
    it = ok; it.rel = -63'sd5;                 send_beat(it);
    it = ok; it.dl = ok.rel;                   send_beat(it);
    it = ok; it.now = 63'h4000_0000_0000_0000; send_beat(it);
    it = ok; it.qb = '1; it.res = 63'(cfg_lim - 1); send_beat(it);  // rate over cap
    it = ok; it.dl = ok.rel + 63'sd1;          send_beat(it);  // window too short
    send_beat(fresh_submit());                                 // nothing pending
    send_beat(ok);
    it = fresh_submit(); it.seq = it.seq + 63'd1; send_beat(it);
    it = fresh_submit(); it.st = 63'(pend_start - 1); send_beat(it);
    it = fresh_submit(); it.dn = 63'(pend_end); send_beat(it);
    it = fresh_submit(); it.st = 63'(pend_end - 2); it.dn = 63'(pend_end - 1); send_beat(it);
    it = fresh_reserve(); it.seq = 63'(seq_last); send_beat(it);  // sequence not rising
    it = fresh_reserve(); it.now = 63'(seen_ns - 1); send_beat(it); // time went back
    it = fresh_reserve(); it.qb = 32'd100000; it.res = '0; it.dl = it.dl + 63'sd100000000;
    send_beat(it);                                             // adapted rate
    send_beat(fresh_submit());
    send_beat(noise_item());
  endtask

  task automatic test_random(int n);
    pace_req_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        it = noise_item();
      end else begin
        it = pend_ok ? fresh_submit() : fresh_reserve();
        if (pick < 22) begin
          case ($urandom_range(0, 4))
            0: it.seq = it.seq ^ (63'd1 << $urandom_range(0, 62));
            1: it.now = it.now - 63'($urandom_range(1, 3000000));
            2: it.st = it.st - 63'($urandom_range(1, 3000000));
            3: it.dn = it.dn + 63'($urandom_range(0, 30000000));
            default: it.op = ~it.op;
          endcase
        end
      end
      send_beat(it);
    end
  endtask

  function automatic void cmp(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      sink_stall <= $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pace_rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual status %0d",
                 $time, status_o);
      end else begin
        e = grant_q.pop_front();
        cmp("status", e.status, status_o);
        cmp("win_open_ns", e.nb, win_open_ns_o);
        cmp("win_close_ns", e.na, win_close_ns_o);
        cmp("serve_ns", e.dur, serve_ns_o);
        cmp("granted_rate", e.rate, granted_rate_o);
        cmp("reserved_count", e.n_resv, reserved_count_o);
        cmp("submitted_count", e.n_subm, submitted_count_o);
        cmp("adaptation_count", e.n_adapt, adaptation_count_o);
        cmp("peak_rate", e.peak, peak_rate_o);
        cmp("max_lateness_ns", e.late, max_lateness_ns_o);
        cmp("worst_late_sequence", e.late_seq, worst_late_sequence_o);
        cmp("saturated", e.sat, saturated_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL datagram_deadline_pacer_core");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(280);
    program_rates(1, 64'hFFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF);
    test_random(230);
    program_rates(1000000, 999999, 100000000, 1);   // cap below base
    test_random(40);
    program_rates(125000, 64'hFFFF_FFFF, 1, 2);     // smallest queue limit
    test_random(60);
    program_rates(125000, 4000000, 5000000, 7);
    test_random(270);
    quiet = 1'b1;
    test_random(150);
    drain();
    if (errors == 0) begin
      $display("PASS datagram_deadline_pacer_core");
    end else begin
      $display("FAIL datagram_deadline_pacer_core");
    end
    $finish;
  end

endmodule
